// ===== hw/rtl/int32_to_decimal_ascii_macros.svh =====
// Assertion macros for the decimal ASCII printer.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef INT32_TO_DECIMAL_ASCII_MACROS_SVH
`define INT32_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication
`define I2DA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2da: check failed");

// next-cycle implication
`define I2DA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2da: check failed");

`endif

// ===== hw/rtl/i2da_pkg.sv =====
// Shared types and constants for the decimal ASCII printer.
// No dependencies.
package i2da_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int REM_W      = 4;
    localparam int BITCNT_W   = 5;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic       busy;
        logic       load;
        cell_ctrl_t chain;
        logic       emit_sign;
        logic       emit_digit;
        logic       last;
    } ctl_t;

endpackage

// ===== hw/rtl/int32_to_decimal_ascii.sv =====
// Top level of the 32-bit binary to decimal ASCII printer.
// Depends on i2da_pkg, i2da_digit_cell and i2da_ctrl.
//
// A word is taken when start is high and busy is low. The magnitude is shifted
// through a chain of ten shift-add-3 BCD digit cells, one bit per cycle, until
// every bit is in; then a '-' goes out for a negative signed word, leading zeros
// are shifted out of the chain one per cycle, and each remaining digit goes out
// one per cycle, most significant first, with last on the final one.
// Each character is on character/last for the single cycle strobe is high;
// the receiver has no way to stall and must take it then.
module int32_to_decimal_ascii (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] value,
    input  logic        is_signed,
    output logic        strobe,
    output logic [7:0]  character,
    output logic        last
);
    import i2da_pkg::*;

    ctl_t               ctl;
    logic [VALUE_W-1:0] mag_reg;
    logic               neg_reg;
    logic               in_neg;
    logic               strobe_reg;
    logic [7:0]         character_reg;
    logic               last_reg;
    logic [DIGIT_W-1:0] digits [NUM_DIGITS];
    logic [NUM_DIGITS-1:0] carries;

    assign in_neg = is_signed & value[VALUE_W-1];

    i2da_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .neg       (neg_reg),
        .top_digit (digits[NUM_DIGITS-1]),
        .ctl       (ctl)
    );

    for (genvar i = 0; i < NUM_DIGITS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_first
            i2da_digit_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctl.chain),
                .carry_in  (mag_reg[VALUE_W-1]),
                .digit_in  ('0),
                .carry_out (carries[i]),
                .digit     (digits[i])
            );
        end
        else
        begin : g_rest
            i2da_digit_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctl.chain),
                .carry_in  (carries[i-1]),
                .digit_in  (digits[i-1]),
                .carry_out (carries[i]),
                .digit     (digits[i])
            );
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            mag_reg <= in_neg ? (VALUE_W'(0) - value) : value;
            neg_reg <= in_neg;
        end
        else if (ctl.chain.dabble)
        begin
            mag_reg <= {mag_reg[VALUE_W-2:0], 1'b0};
        end
        character_reg <= ctl.emit_sign ? CHAR_MINUS
                                       : CHAR_ZERO + {4'b0000, digits[NUM_DIGITS-1]};
        last_reg      <= ctl.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= ctl.emit_sign | ctl.emit_digit;
        end
    end

    assign busy      = ctl.busy;
    assign strobe    = strobe_reg;
    assign character = character_reg;
    assign last      = last_reg & strobe_reg;

endmodule

// ===== hw/rtl/i2da_digit_cell.sv =====
// One BCD digit cell of the shift-add-3 chain.
// Depends on i2da_pkg.
module i2da_digit_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  i2da_pkg::cell_ctrl_t         ctrl,
    input  logic                         carry_in,
    input  logic [i2da_pkg::DIGIT_W-1:0] digit_in,
    output logic                         carry_out,
    output logic [i2da_pkg::DIGIT_W-1:0] digit
);
    import i2da_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] adj;

    assign adj       = (digit_reg >= DIGIT_W'(5)) ? digit_reg + DIGIT_W'(3) : digit_reg;
    assign carry_out = adj[DIGIT_W-1];
    assign digit     = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.dabble)
        begin
            digit_next = {adj[DIGIT_W-2:0], carry_in};
        end
        else if (ctrl.shift)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

// ===== hw/rtl/i2da_ctrl.sv =====
// Sequencer: conversion, sign, leading-zero skip and digit emission.
// Depends on i2da_pkg.
module i2da_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         neg,
    input  logic [i2da_pkg::DIGIT_W-1:0] top_digit,
    output i2da_pkg::ctl_t               ctl
);
    import i2da_pkg::*;

    state_t              state_reg, state_next;
    logic [BITCNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic                rem_one;
    logic                conv_done;
    logic                skip_emit;

    assign rem_one   = (rem_reg == REM_W'(1));
    assign conv_done = (bit_cnt_reg == BITCNT_W'(VALUE_W - 1));
    assign skip_emit = (top_digit != '0) || rem_one;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (conv_done)
                begin
                    state_next = neg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN:
            begin
                state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                if (skip_emit)
                begin
                    state_next = rem_one ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (rem_one)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        bit_cnt_next = bit_cnt_reg;
        rem_next     = rem_reg;
        case (state_reg)
            ST_IDLE:
            begin
                bit_cnt_next = '0;
            end
            ST_CONVERT:
            begin
                bit_cnt_next = bit_cnt_reg + BITCNT_W'(1);
                rem_next     = REM_W'(NUM_DIGITS);
            end
            ST_SKIP, ST_EMIT:
            begin
                rem_next = rem_reg - REM_W'(1);
            end
            default:
            begin
                bit_cnt_next = bit_cnt_reg;
            end
        endcase
    end

    always_comb
    begin
        ctl = '0;
        ctl.busy = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                ctl.load        = start;
                ctl.chain.clear = start;
            end
            ST_CONVERT:
            begin
                ctl.chain.dabble = 1'b1;
            end
            ST_SIGN:
            begin
                ctl.emit_sign = 1'b1;
            end
            ST_SKIP:
            begin
                ctl.chain.shift = 1'b1;
                ctl.emit_digit  = skip_emit;
                ctl.last        = rem_one;
            end
            ST_EMIT:
            begin
                ctl.chain.shift = 1'b1;
                ctl.emit_digit  = 1'b1;
                ctl.last        = rem_one;
            end
            default:
            begin
                ctl.busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            rem_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            rem_reg     <= rem_next;
        end
    end

endmodule

// ===== hw/rtl/i2da_checker.sv =====
// Port-level checks for int32_to_decimal_ascii, bound to the top level.
// Depends on i2da_pkg and int32_to_decimal_ascii_macros.svh.
`include "int32_to_decimal_ascii_macros.svh"

module i2da_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       strobe,
    input logic [7:0] character,
    input logic       last
);
    import i2da_pkg::*;

    `I2DA_ASSERT_NEXT(a_take_sets_busy, start && !busy, busy && !strobe)
    `I2DA_ASSERT_NOW(a_last_frees, strobe && last, !busy)
    `I2DA_ASSERT_NOW(a_mid_word_busy, strobe && !last, busy)
    `I2DA_ASSERT_NOW(a_minus_not_last, strobe && (character == CHAR_MINUS), !last)

endmodule

bind int32_to_decimal_ascii i2da_checker u_i2da_checker (.*);
